// ===== hdl/cve_pkg.sv =====
// shared types, constants and register codes of the cbc vigenere encryptor
package cve_pkg;

   localparam int MAX_BLOCK  = 12;
   localparam int POS_W      = $clog2(MAX_BLOCK + 1);
   localparam int LETTER_W   = 5;
   localparam int CHAR_W     = 8;
   localparam int ASCII_W    = 7;
   localparam int COUNT_W    = 24;
   localparam int KEY_W      = MAX_BLOCK * LETTER_W;
   localparam int SUM_W      = 7;
   localparam int CSR_IDX_W  = 2;

   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [POS_W-1:0]    pos_type;
   typedef logic [CHAR_W-1:0]   char_type;
   typedef logic [ASCII_W-1:0]  ascii_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [KEY_W-1:0]    key_type;
   typedef logic [SUM_W-1:0]    sum_type;

   localparam sum_type   ALPHA_SIZE  = 7'd26;
   localparam char_type  LOWER_A     = 8'd97;
   localparam char_type  LOWER_Z     = 8'd122;
   localparam char_type  UPPER_A     = 8'd65;
   localparam char_type  BELOW_UPPER = 8'd64;
   localparam char_type  ABOVE_UPPER = 8'd91;
   localparam ascii_type ASCII_A     = 7'd97;
   localparam ascii_type ASCII_Z     = 7'd122;
   localparam letter_type PAD_LETTER = 5'd23;
   localparam count_type COUNT_MAX   = {COUNT_W{1'b1}};
   localparam pos_type   POS_ONE     = POS_W'(1);
   localparam pos_type   POS_MAX     = POS_W'(MAX_BLOCK);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCK_LEN = 2'd0,
      CSR_KEY       = 2'd1,
      CSR_IV        = 2'd2
   } csr_index_type;

endpackage

// ===== hdl/cve_chan_if.sv =====
// valid/ready channel interfaces for text words and cipher words
interface cve_req_if import cve_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     kind;
   char_type char_code;

   modport source (output valid, kind, char_code, input ready);
   modport sink   (input valid, kind, char_code, output ready);
endinterface

interface cve_rsp_if import cve_pkg::*; ();
   logic      valid;
   logic      ready;
   ascii_type cipher_char;
   logic      has_letter;
   logic      is_pad;
   logic      last;
   count_type clean_count;

   modport source (output valid, cipher_char, has_letter, is_pad, last, clean_count,
                   input ready);
   modport sink   (input valid, cipher_char, has_letter, is_pad, last, clean_count,
                   output ready);
endinterface

// ===== hdl/cve_mix.sv =====
// adds plaintext, key and chain letters modulo 26
module cve_mix import cve_pkg::*; (
   input  letter_type plain_letter,
   input  letter_type key_letter,
   input  letter_type prev_letter,
   output letter_type cipher_letter
);

   sum_type sum;
   sum_type reduced;

   assign sum = SUM_W'(plain_letter) + SUM_W'(key_letter) + SUM_W'(prev_letter);

   // sum stays below four times the alphabet size
   always_comb begin
      priority if (sum >= SUM_W'(3 * ALPHA_SIZE)) begin
         reduced = sum - SUM_W'(3 * ALPHA_SIZE);
      end else if (sum >= SUM_W'(2 * ALPHA_SIZE)) begin
         reduced = sum - SUM_W'(2 * ALPHA_SIZE);
      end else if (sum >= ALPHA_SIZE) begin
         reduced = sum - ALPHA_SIZE;
      end else begin
         reduced = sum;
      end
   end

   assign cipher_letter = reduced[LETTER_W-1:0];

endmodule

// ===== hdl/cbc_vigenere_encrypt_unit.sv =====
// top level of the cbc chained vigenere encryptor
//
// Text words enter one per cycle: each letter is encrypted in a single step
// between the input register and the result register, so a stream of text
// words runs at one word per cycle while the result channel takes each word,
// and non-letter words are absorbed without a result. An end-of-message word
// holds the input register while pad letters are made (up to 11, one step of
// the encrypt unit and one chain store write each), or gives a bare end word
// when no block is open. block_len, key_letters and iv_letters may only be
// written while the block is idle; chain letters survive the end of a message.
module cbc_vigenere_encrypt_unit import cve_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   cve_req_if.sink       req_chan,
   cve_rsp_if.source     rsp_chan,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  key_type       csr_wdata
);

   // configuration
   pos_type block_len_ff;
   key_type key_ff;
   key_type iv_ff;

   // input register
   logic     in_valid_ff, in_valid_in;
   logic     in_kind_ff;
   char_type in_char_ff;

   // message state
   pos_type    pos_ff, pos_in;
   logic       first_ff, first_in;
   count_type  count_ff, count_in;
   letter_type chain_ff [MAX_BLOCK];

   // result register
   logic      out_valid_ff, out_valid_in;
   ascii_type out_char_ff, out_char_in;
   logic      out_has_ff, out_has_in;
   logic      out_pad_ff, out_pad_in;
   logic      out_last_ff, out_last_in;
   count_type out_count_ff, out_count_in;

   pos_type    len_eff;
   logic       pos_over;
   pos_type    pos_fix;
   logic       first_fix;
   pos_type    pos_next;
   logic       wrap;
   letter_type key_arr [MAX_BLOCK];
   letter_type iv_arr  [MAX_BLOCK];
   char_type   lower_off;
   char_type   upper_off;
   logic       is_lower, is_upper;
   logic       is_letter_item, is_end_item, is_bare_end;
   logic       need_out, slot_free, fire, in_done, encrypting;
   letter_type plain_letter, prev_letter, cipher_letter;
   count_type  count_inc;

   always_comb begin
      for (int j = 0; j < MAX_BLOCK; j++) begin
         key_arr[j] = key_ff[j*LETTER_W +: LETTER_W];
         iv_arr[j]  = iv_ff[j*LETTER_W +: LETTER_W];
      end
   end

   always_comb begin
      priority if (block_len_ff == '0) begin
         len_eff = POS_ONE;
      end else if (block_len_ff > POS_MAX) begin
         len_eff = POS_MAX;
      end else begin
         len_eff = block_len_ff;
      end
   end

   // a shortened block length closes the open block
   assign pos_over  = pos_ff >= len_eff;
   assign pos_fix   = pos_over ? '0 : pos_ff;
   assign first_fix = pos_over ? 1'b0 : first_ff;
   assign pos_next  = pos_fix + POS_ONE;
   assign wrap      = pos_next >= len_eff;

   assign lower_off = in_char_ff - LOWER_A;
   assign upper_off = in_char_ff - UPPER_A;
   assign is_lower  = (in_char_ff >= LOWER_A) && (in_char_ff <= LOWER_Z);
   assign is_upper  = (in_char_ff > BELOW_UPPER) && (in_char_ff < ABOVE_UPPER);

   assign is_letter_item = in_valid_ff && !in_kind_ff && (is_lower || is_upper);
   assign is_end_item    = in_valid_ff && in_kind_ff;
   assign is_bare_end    = is_end_item && (pos_fix == '0);
   assign need_out       = is_letter_item || is_end_item;
   assign slot_free      = !out_valid_ff || rsp_chan.ready;
   assign fire           = in_valid_ff && (!need_out || slot_free);
   assign in_done        = fire && (!is_end_item || is_bare_end || wrap);
   assign encrypting     = fire && (is_letter_item || (is_end_item && !is_bare_end));

   assign req_chan.ready = !in_valid_ff || in_done;

   always_comb begin
      priority if (is_end_item) begin
         plain_letter = PAD_LETTER;
      end else if (is_lower) begin
         plain_letter = lower_off[LETTER_W-1:0];
      end else begin
         plain_letter = upper_off[LETTER_W-1:0];
      end
   end

   assign prev_letter = first_fix ? iv_arr[pos_fix] : chain_ff[pos_fix];

   cve_mix u_mix (
      .plain_letter  (plain_letter),
      .key_letter    (key_arr[pos_fix]),
      .prev_letter   (prev_letter),
      .cipher_letter (cipher_letter)
   );

   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_W'(1);

   always_comb begin
      in_valid_in = in_valid_ff;
      pos_in      = pos_ff;
      first_in    = first_ff;
      count_in    = count_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (in_done) begin
         in_valid_in = 1'b0;
      end
      if (fire) begin
         pos_in   = pos_fix;
         first_in = first_fix;
         if (encrypting) begin
            pos_in   = wrap ? '0 : pos_next;
            first_in = wrap ? 1'b0 : first_fix;
         end
         if (is_letter_item) begin
            count_in = count_inc;
         end
         if (is_end_item && in_done) begin
            pos_in   = '0;
            first_in = 1'b1;
            count_in = '0;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_has_in   = out_has_ff;
      out_pad_in   = out_pad_ff;
      out_last_in  = out_last_ff;
      out_count_in = out_count_ff;
      if (fire && need_out) begin
         out_valid_in = 1'b1;
         out_has_in   = !is_bare_end;
         out_char_in  = is_bare_end ? '0 : ASCII_A + ASCII_W'(cipher_letter);
         out_pad_in   = is_end_item && !is_bare_end;
         out_last_in  = is_end_item && (is_bare_end || wrap);
         out_count_in = is_letter_item ? count_inc : count_ff;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_len_ff <= POS_ONE;
         key_ff       <= '0;
         iv_ff        <= '0;
         in_valid_ff  <= 1'b0;
         pos_ff       <= '0;
         first_ff     <= 1'b1;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_BLOCK_LEN: block_len_ff <= csr_wdata[POS_W-1:0];
               CSR_KEY:       key_ff       <= csr_wdata;
               CSR_IV:        iv_ff        <= csr_wdata;
               default:       ;
            endcase
         end
         in_valid_ff  <= in_valid_in;
         pos_ff       <= pos_in;
         first_ff     <= first_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_kind_ff <= req_chan.kind;
         in_char_ff <= req_chan.char_code;
      end
      if (encrypting) begin
         chain_ff[pos_fix] <= cipher_letter;
      end
      out_char_ff  <= out_char_in;
      out_has_ff   <= out_has_in;
      out_pad_ff   <= out_pad_in;
      out_last_ff  <= out_last_in;
      out_count_ff <= out_count_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.cipher_char = out_char_ff;
   assign rsp_chan.has_letter  = out_has_ff;
   assign rsp_chan.is_pad      = out_pad_ff;
   assign rsp_chan.last        = out_last_ff;
   assign rsp_chan.clean_count = out_count_ff;

endmodule

// ===== hdl/cve_checker.sv =====
// port checks on the result channel of the encryptor, bound to the top level
module cve_checker import cve_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input ascii_type cipher_char,
   input logic      has_letter,
   input logic      is_pad,
   input logic      last,
   input count_type clean_count
);

   // no word is offered right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word offered after reset");

   // a bare end word carries no letter and closes the message
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !has_letter |-> last && !is_pad && (cipher_char == '0))
      else $error("bare end word malformed");

   // a letter word may close a message only as a pad letter
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && has_letter && (last || is_pad) |-> is_pad)
      else $error("letter word flagged last without padding");

   // letter words carry a lowercase code and text letters count themselves
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && has_letter |-> (cipher_char >= ASCII_A) && (cipher_char <= ASCII_Z)
         && (is_pad || (clean_count != '0)))
      else $error("letter word out of range");

   // a stalled word holds its valid, code, last flag and count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(cipher_char) && $stable(last)
         && $stable(clean_count))
      else $error("stalled result word changed");

endmodule

bind cbc_vigenere_encrypt_unit cve_checker u_cve_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .cipher_char (rsp_chan.cipher_char),
   .has_letter  (rsp_chan.has_letter),
   .is_pad      (rsp_chan.is_pad),
   .last        (rsp_chan.last),
   .clean_count (rsp_chan.clean_count)
);
